FILE: rtl/pas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types, constants and command/status bundles for the pulse/saw
// sound channel block.
// ----------------------------------------------------------------------------
package pas_pkg;

  // add-back steps allowed per channel per tick
  localparam int MAX_STEPS_PER_TICK = 64;
  localparam int STEP_CNT_W         = $clog2(MAX_STEPS_PER_TICK + 1);
  localparam logic [STEP_CNT_W-1:0] STEP_CNT_MAX = STEP_CNT_W'(MAX_STEPS_PER_TICK);

  localparam int STEP_W = 25;  // phase step, 18 fraction bits
  localparam int REM_W  = 30;  // remainder stays below 4096 << 18
  localparam int WORK_W = 32;  // signed working remainder
  localparam int FRAC_W = 18;

  // channel numbers
  localparam logic [1:0] CH_PULSE_A = 2'd0;
  localparam logic [1:0] CH_PULSE_B = 2'd1;
  localparam logic [1:0] CH_SAW     = 2'd2;

  // address nibble (bits 15..12) per channel
  localparam logic [3:0] NIB_PULSE_A = 4'h9;
  localparam logic [3:0] NIB_PULSE_B = 4'hA;
  localparam logic [3:0] NIB_SAW     = 4'hB;

  // channel register indexes
  localparam logic [1:0] REG_CTRL   = 2'd0;
  localparam logic [1:0] REG_PER_LO = 2'd1;
  localparam logic [1:0] REG_PER_HI = 2'd2;
  localparam logic [1:0] REG_NONE   = 2'd3;

  // saw wraps after this many steps
  localparam logic [2:0] SAW_STEPS = 3'd7;

  // configuration register indexes
  localparam logic CFG_IDX_PULSE = 1'b0;
  localparam logic CFG_IDX_SAW   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_DONE
  } pas_state_t;

  typedef struct packed {
    logic       reg_write;  // store the accepted bus write
    logic       load;       // work = remainder - step, clear step count
    logic       add_back;   // work += period, advance channel
    logic       store;      // write work back to remainder
    logic       emit;       // capture levels into output register
    logic [1:0] ch;         // channel being worked on
  } pas_cmd_t;

  typedef struct packed {
    logic loaded;     // selected channel has its period loaded
    logic step_more;  // work negative and step budget left
    logic out_free;   // output register can take a beat
  } pas_sts_t;

endpackage : pas_pkg
`default_nettype wire

FILE: rtl/pas_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_cfg
// APB register file holding the pulse and saw phase steps.
// ----------------------------------------------------------------------------
module pas_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic      [pas_pkg::STEP_W-1:0] pulse_step,
  output logic      [pas_pkg::STEP_W-1:0] saw_step
);
  import pas_pkg::*;

  logic [STEP_W-1:0] pulse_step_r;
  logic [STEP_W-1:0] saw_step_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register select is paddr[2]; byte lanes are not decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_step_r <= '0;
      saw_step_r   <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        CFG_IDX_PULSE: pulse_step_r <= pwdata[STEP_W-1:0];
        CFG_IDX_SAW:   saw_step_r   <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_PULSE: prdata = {{(32-STEP_W){1'b0}}, pulse_step_r};
      CFG_IDX_SAW:   prdata = {{(32-STEP_W){1'b0}}, saw_step_r};
      default:       prdata = '0;
    endcase
  end

  assign pulse_step = pulse_step_r;
  assign saw_step   = saw_step_r;

endmodule : pas_cfg
`default_nettype wire

FILE: rtl/pas_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_ctrl
// Sequencer: walks the three channels on a tick, skips unloaded ones, loads
// each remainder, runs the add-back loop, stores it and hands the levels out.
// ----------------------------------------------------------------------------
module pas_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_is_tick,
  output logic                   in_ready,
  input  wire pas_pkg::pas_sts_t sts,
  output pas_pkg::pas_cmd_t      cmd
);
  import pas_pkg::*;

  pas_state_t state_r, state_nxt;
  logic [1:0] ch_r, ch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= CH_PULSE_A;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_is_tick) begin
          state_nxt = ST_LOAD;
          ch_nxt    = CH_PULSE_A;
        end
      end
      ST_LOAD: begin
        if (sts.loaded) begin
          state_nxt = ST_STEP;
        end else if (ch_r == CH_SAW) begin
          state_nxt = ST_DONE;
        end else begin
          ch_nxt = ch_r + 2'd1;
        end
      end
      ST_STEP: begin
        if (!sts.step_more) begin
          if (ch_r == CH_SAW) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_LOAD;
            ch_nxt    = ch_r + 2'd1;
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.ch   = ch_r;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.reg_write = in_valid && !in_is_tick;
      end
      ST_LOAD: cmd.load = sts.loaded;
      ST_STEP: begin
        cmd.add_back = sts.step_more;
        cmd.store    = !sts.step_more;
      end
      ST_DONE: cmd.emit = sts.out_free;
      default: ;
    endcase
  end

  a_ch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (ch_r != REG_NONE))
    else $error("channel counter out of range");

  a_tick_starts_a: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_is_tick) |=>
      (state_r == ST_LOAD && ch_r == CH_PULSE_A))
    else $error("tick did not start at first channel");

  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !sts.out_free) |=> (state_r == ST_DONE))
    else $error("left done state with output register full");

endmodule : pas_ctrl
`default_nettype wire

FILE: rtl/pas_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pas_dp
// Channel registers, phase remainders, step counters and the shared
// add-back adder, plus the output register.
// ----------------------------------------------------------------------------
module pas_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pas_pkg::pas_cmd_t          cmd,
  output pas_pkg::pas_sts_t               sts,
  input  wire logic [15:0]                bus_address,
  input  wire logic [7:0]                 write_data,
  input  wire logic [pas_pkg::STEP_W-1:0] pulse_step,
  input  wire logic [pas_pkg::STEP_W-1:0] saw_step,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [3:0]                      pulse_a_level,
  output logic [3:0]                      pulse_b_level,
  output logic [4:0]                      saw_level
);
  import pas_pkg::*;

  logic [7:0]            regs_r [3][3];  // [channel][register]
  logic                  loaded_r [3];
  logic [REM_W-1:0]      rem_r [3];
  logic [3:0]            duty_r [2];
  logic [2:0]            saw_pos_r;
  logic [8:0]            saw_acc_r;
  logic [WORK_W-1:0]     work_r, work_nxt;
  logic [STEP_CNT_W-1:0] n_r;
  logic                  out_valid_r;
  logic [3:0]            lvl_a_r, lvl_b_r;
  logic [4:0]            lvl_saw_r;

  // bus write decode
  logic       wr_hit;
  logic [1:0] wr_ch;
  logic [1:0] wr_reg;

  always_comb begin
    wr_hit = 1'b1;
    wr_ch  = CH_PULSE_A;
    unique case (bus_address[15:12])
      NIB_PULSE_A: wr_ch = CH_PULSE_A;
      NIB_PULSE_B: wr_ch = CH_PULSE_B;
      NIB_SAW:     wr_ch = CH_SAW;
      default:     wr_hit = 1'b0;
    endcase
    wr_reg = bus_address[1:0];
    if (wr_reg == REG_NONE) wr_hit = 1'b0;
  end

  // add-back operands for the selected channel
  logic [12:0]       period_p1;
  logic [WORK_W-1:0] per;
  logic [STEP_W-1:0] step_sel;

  assign period_p1 = {1'b0, regs_r[cmd.ch][REG_PER_HI][3:0], regs_r[cmd.ch][REG_PER_LO]}
                     + 13'd1;
  assign per       = {1'b0, period_p1, {FRAC_W{1'b0}}};
  assign step_sel  = (cmd.ch == CH_SAW) ? saw_step : pulse_step;

  always_comb begin
    work_nxt = work_r;
    if (cmd.load) begin
      work_nxt = {{(WORK_W-REM_W){1'b0}}, rem_r[cmd.ch]}
               - {{(WORK_W-STEP_W){1'b0}}, step_sel};
    end else if (cmd.add_back) begin
      work_nxt = work_r + per;
    end
  end

  // saw step
  logic [8:0] saw_sum;
  logic [2:0] saw_pos_inc;
  assign saw_sum     = saw_acc_r + {3'd0, regs_r[CH_SAW][REG_CTRL][5:0]};
  assign saw_pos_inc = saw_pos_r + 3'd1;

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) regs_r[c][r] <= '0;
        loaded_r[c] <= 1'b0;
        rem_r[c]    <= '0;
      end
      duty_r[0] <= '0;
      duty_r[1] <= '0;
      saw_pos_r <= '0;
      saw_acc_r <= '0;
      n_r       <= '0;
    end else begin
      if (cmd.reg_write && wr_hit) begin
        regs_r[wr_ch][wr_reg] <= write_data;
        if (wr_reg != REG_CTRL) loaded_r[wr_ch] <= 1'b1;
      end
      if (cmd.load) n_r <= '0;
      if (cmd.add_back) begin
        n_r <= n_r + STEP_CNT_W'(1);
        if (cmd.ch == CH_SAW) begin
          if (saw_pos_inc == SAW_STEPS) begin
            saw_pos_r <= '0;
            saw_acc_r <= '0;
          end else begin
            saw_pos_r <= saw_pos_inc;
            saw_acc_r <= saw_sum;
          end
        end else begin
          duty_r[cmd.ch[0]] <= duty_r[cmd.ch[0]] + 4'd1;
        end
      end
      // budget ran out with work still negative: clamp to zero
      if (cmd.store) rem_r[cmd.ch] <= work_r[WORK_W-1] ? '0 : work_r[REM_W-1:0];
    end
  end

  // level computation from the settled channel state
  logic [3:0] pulse_lvl [2];
  logic [4:0] saw_lvl;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      pulse_lvl[c] = regs_r[c][REG_CTRL][3:0];
      if (!loaded_r[c] || !regs_r[c][REG_PER_HI][7]) pulse_lvl[c] = '0;
      // gated while duty position sits at or below the duty setting, unless ctrl bit 7 is set
      if (!regs_r[c][REG_CTRL][7] && (duty_r[c] <= {1'b0, regs_r[c][REG_CTRL][6:4]}))
        pulse_lvl[c] = '0;
    end
    saw_lvl = saw_acc_r[7:3];
    if (!loaded_r[CH_SAW] || !regs_r[CH_SAW][REG_PER_HI][7]) saw_lvl = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      lvl_a_r   <= pulse_lvl[0];
      lvl_b_r   <= pulse_lvl[1];
      lvl_saw_r <= saw_lvl;
    end
  end

  assign sts.loaded    = loaded_r[cmd.ch];
  assign sts.step_more = work_r[WORK_W-1] && (n_r < STEP_CNT_MAX);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign pulse_a_level = lvl_a_r;
  assign pulse_b_level = lvl_b_r;
  assign saw_level     = lvl_saw_r;

  a_step_budget: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_back |-> (n_r < STEP_CNT_MAX))
    else $error("add-back beyond step budget");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !out_valid_r) |=> out_valid_r)
    else $error("emitted beat not presented");

endmodule : pas_dp
`default_nettype wire

FILE: rtl/pulse_and_saw_sound_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_and_saw_sound_channels
// Two pulse channels and one sawtooth channel with linear level outputs.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_*     in   tuser: 0 register write / 1 sample tick; tdata: address, data
//  out_*    out  one beat per tick: pulse A, pulse B, saw levels
//  cfg_*    in   APB: 0x0 pulse phase step, 0x4 saw phase step (25 bits)
//
// Register write beat: accepted in the idle cycle, done in that cycle.
// Sample tick: accepted in the idle cycle, then per loaded channel the
//   remainder is loaded, up to 64 add-backs run on the one shared adder
//   and the result is stored (an unloaded channel is skipped); then the
//   output register is loaded.
// Reset (rst_n low, synchronous) zeroes all channel state and both steps.
// in_tready is low while a tick is in flight; a tick stalls at its end
//   until out_tready frees the output register. Writes wait as well.
// ----------------------------------------------------------------------------
module pulse_and_saw_sound_channels (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [15:0] bus_address, [23:16] write_data
  input  wire logic        in_tuser,   // [0] op
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [3:0] pulse_a_level, [7:4] pulse_b_level,
                                       // [12:8] saw_level, [15:13] zero
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import pas_pkg::*;

  pas_cmd_t          cmd;
  pas_sts_t          sts;
  logic [STEP_W-1:0] pulse_step;
  logic [STEP_W-1:0] saw_step;
  logic [3:0]        lvl_a;
  logic [3:0]        lvl_b;
  logic [4:0]        lvl_saw;

  pas_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .pulse_step (pulse_step),
    .saw_step   (saw_step)
  );

  // sequencer; in_tready comes straight from its idle state
  pas_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_is_tick (in_tuser),
    .in_ready   (in_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pas_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .bus_address   (in_tdata[15:0]),
    .write_data    (in_tdata[23:16]),
    .pulse_step    (pulse_step),
    .saw_step      (saw_step),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .pulse_a_level (lvl_a),
    .pulse_b_level (lvl_b),
    .saw_level     (lvl_saw)
  );

  assign out_tdata = {3'b000, lvl_saw, lvl_b, lvl_a};

endmodule : pulse_and_saw_sound_channels
`default_nettype wire
